FILE: design/dts_pkg.sv
// ----------------------------------------------------------------------------
// Detection target selector package
// Shared widths, codes, beat types and helpers of the target selector.
// ----------------------------------------------------------------------------
package dts_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int NUM_CLASSES = 64;
   localparam int COORD_W     = FRAC_BITS + 1;
   localparam int SUM_W       = COORD_W + 1;
   localparam int CLASS_W     = 6;
   localparam int MASK_W      = 64;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_CONF_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_MASK     = CSR_IDX_W'(1);

   localparam logic [COORD_W-1:0] CONF_THRESHOLD_RESET = COORD_W'(longint'(1) << (FRAC_BITS - 1));

   localparam logic KIND_BOX       = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   localparam logic RESULT_BOX     = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   localparam logic [1:0] EVENT_NONE     = 2'd0;
   localparam logic [1:0] EVENT_DETECTED = 2'd1;
   localparam logic [1:0] EVENT_LOST     = 2'd2;

   typedef struct packed {
      logic               kind;
      logic [CLASS_W-1:0] class_index;
      logic [COORD_W-1:0] ymin;
      logic [COORD_W-1:0] xmin;
      logic [COORD_W-1:0] ymax;
      logic [COORD_W-1:0] xmax;
      logic [COORD_W-1:0] confidence;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic [COORD_W-1:0] box_x;
      logic [COORD_W-1:0] box_y;
      logic [COORD_W-1:0] box_w;
      logic [COORD_W-1:0] box_h;
      logic [CLASS_W-1:0] box_class;
      logic               best_present;
      logic [1:0]         status_event;
   } rsp_type;

   typedef struct packed {
      logic               kind;
      logic [CLASS_W-1:0] class_index;
      logic [COORD_W-1:0] ymin;
      logic [COORD_W-1:0] xmin;
      logic [COORD_W-1:0] ymax;
      logic [COORD_W-1:0] xmax;
      logic [COORD_W-1:0] confidence;
      logic [SUM_W-1:0]   sum_x;
      logic [SUM_W-1:0]   sum_y;
   } mid_type;

   function automatic logic [COORD_W-1:0] span(input logic [COORD_W-1:0] lo,
                                                input logic [COORD_W-1:0] hi);
      return (hi > lo) ? (hi - lo) : '0;
   endfunction

endpackage

FILE: design/dts_fifo.sv
// ----------------------------------------------------------------------------
// Small register queue
// Holds a few beats between two stages so that each side can stall alone.
// ----------------------------------------------------------------------------
module dts_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/dts_front.sv
// ----------------------------------------------------------------------------
// Target selector front end
// Holds the configuration registers, filters boxes by class and confidence
// and forwards frame ends and surviving boxes with their doubled centers.
// ----------------------------------------------------------------------------
module dts_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dts_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            req_push,
   output logic                            req_full,
   input  dts_pkg::req_type                req_data,
   input  logic                            mid_full,
   output logic                            mid_push,
   output dts_pkg::mid_type                mid_data
);

   import dts_pkg::*;

   logic [COORD_W-1:0] threshold_ff, threshold_in;
   logic [MASK_W-1:0]  class_mask_ff, class_mask_in;
   logic               class_ok;
   logic               conf_ok;
   logic               forward;

   assign csr_ready = 1'b1;

   always_comb begin
      threshold_in  = threshold_ff;
      class_mask_in = class_mask_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_CONF_THRESHOLD: threshold_in  = csr_data[COORD_W-1:0];
            CSR_CLASS_MASK:     class_mask_in = csr_data[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= CONF_THRESHOLD_RESET;
         class_mask_ff <= '0;
      end else begin
         threshold_ff  <= threshold_in;
         class_mask_ff <= class_mask_in;
      end
   end

   assign class_ok = ({1'b0, req_data.class_index} < (CLASS_W + 1)'(NUM_CLASSES))
                     && ((class_mask_ff == '0) || class_mask_ff[req_data.class_index]);
   assign conf_ok  = (req_data.confidence >= threshold_ff);
   assign forward  = (req_data.kind == KIND_FRAME_END) || (class_ok && conf_ok);

   assign req_full = mid_full;
   assign mid_push = req_push && !mid_full && forward;

   always_comb begin
      mid_data.kind        = req_data.kind;
      mid_data.class_index = req_data.class_index;
      mid_data.ymin        = req_data.ymin;
      mid_data.xmin        = req_data.xmin;
      mid_data.ymax        = req_data.ymax;
      mid_data.xmax        = req_data.xmax;
      mid_data.confidence  = req_data.confidence;
      mid_data.sum_x       = {1'b0, req_data.xmin} + {1'b0, req_data.xmax};
      mid_data.sum_y       = {1'b0, req_data.ymin} + {1'b0, req_data.ymax};
   end

endmodule

FILE: design/dts_back.sv
// ----------------------------------------------------------------------------
// Target selector back end
// Emits accepted boxes and frame summaries, scores each box over a short
// sequence of arithmetic steps and tracks the best box of the frame.
// ----------------------------------------------------------------------------
module dts_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             mid_empty,
   output logic             mid_pop,
   input  dts_pkg::mid_type mid_data,
   input  logic             out_full,
   output logic             out_push,
   output dts_pkg::rsp_type out_data
);

   import dts_pkg::*;

   localparam int DW    = FRAC_BITS + 3;
   localparam int SQ_W  = 2 * DW;
   localparam int AP_W  = 2 * SUM_W;
   localparam int TW    = FRAC_BITS + 8;
   localparam int PRW   = FRAC_BITS + 1 + TW;
   localparam int SCW   = PRW + 2;
   localparam int SC_W  = FRAC_BITS + 3;

   localparam logic signed [DW-1:0]  ONE_D = DW'(longint'(1) << FRAC_BITS);
   localparam logic signed [TW-1:0]  ONE_T = TW'(longint'(1) << FRAC_BITS);
   localparam logic [FRAC_BITS-1:0]  W_30  =
      FRAC_BITS'((3 * (longint'(1) << FRAC_BITS) + 5) / 10);
   localparam logic [FRAC_BITS-1:0]  W_15  =
      FRAC_BITS'((3 * (longint'(1) << FRAC_BITS) + 10) / 20);
   localparam logic [FRAC_BITS-1:0]  W_05  =
      FRAC_BITS'(((longint'(1) << FRAC_BITS) + 10) / 20);
   localparam logic signed [SCW-1:0] SAT_HI = SCW'((longint'(1) << (FRAC_BITS + 2)) - 1);
   localparam logic signed [SCW-1:0] SAT_LO = SCW'(-(longint'(1) << (FRAC_BITS + 2)));

   typedef enum logic [1:0] {ST_IDLE, ST_SUM, ST_WGT, ST_FIN} state_type;

   state_type state_ff, state_in;

   logic               prev_valid_ff, prev_valid_in;
   logic               best_valid_ff, best_valid_in;
   logic               found_in_frame_ff, found_in_frame_in;
   logic               found_reported_ff, found_reported_in;

   logic [COORD_W-1:0] prev_cx_ff, prev_cx_in;
   logic [COORD_W-1:0] prev_cy_ff, prev_cy_in;
   logic signed [SC_W-1:0] top_score_ff, top_score_in;
   logic [COORD_W-1:0] best_xmin_ff, best_xmin_in;
   logic [COORD_W-1:0] best_ymin_ff, best_ymin_in;
   logic [COORD_W-1:0] best_xmax_ff, best_xmax_in;
   logic [COORD_W-1:0] best_ymax_ff, best_ymax_in;
   logic [CLASS_W-1:0] best_class_ff, best_class_in;

   logic [COORD_W-1:0] cur_xmin_ff, cur_xmin_in;
   logic [COORD_W-1:0] cur_ymin_ff, cur_ymin_in;
   logic [COORD_W-1:0] cur_xmax_ff, cur_xmax_in;
   logic [COORD_W-1:0] cur_ymax_ff, cur_ymax_in;
   logic [COORD_W-1:0] cur_conf_ff, cur_conf_in;
   logic [CLASS_W-1:0] cur_class_ff, cur_class_in;

   logic [SQ_W-1:0]        dx_sq_ff, dx_sq_in;
   logic [SQ_W-1:0]        dy_sq_ff, dy_sq_in;
   logic [SQ_W-1:0]        px_sq_ff, px_sq_in;
   logic [SQ_W-1:0]        py_sq_ff, py_sq_in;
   logic signed [AP_W-1:0] area_prod_ff, area_prod_in;
   logic signed [TW-1:0]   om_dc_ff, om_dc_in;
   logic signed [TW-1:0]   om_dp_ff, om_dp_in;
   logic signed [TW-1:0]   area_q_ff, area_q_in;
   logic signed [PRW-1:0]  t30_ff, t30_in;
   logic signed [PRW-1:0]  t15_ff, t15_in;
   logic signed [PRW-1:0]  t05_ff, t05_in;

   logic signed [DW-1:0]    dx, dy, px, py;
   logic signed [SQ_W-1:0]  dx_prod, dy_prod, px_prod, py_prod;
   logic signed [SUM_W-1:0] ew, eh;
   logic [SQ_W:0]           dc_sum, dp_sum, dc_wide, dp_wide;
   logic signed [PRW-1:0]   sh30, sh15, sh05;
   logic signed [SCW-1:0]   conf_half, score_wide;
   logic signed [SC_W-1:0]  score_sat;
   logic [COORD_W:0]        cx_sum, cy_sum;
   logic                    take;

   always_comb begin
      dx = $signed({1'b0, mid_data.sum_x}) - ONE_D;
      dy = $signed({1'b0, mid_data.sum_y}) - ONE_D;
      px = $signed({1'b0, mid_data.sum_x}) - $signed({1'b0, prev_cx_ff, 1'b0});
      py = $signed({1'b0, mid_data.sum_y}) - $signed({1'b0, prev_cy_ff, 1'b0});
      dx_prod = dx * dx;
      dy_prod = dy * dy;
      px_prod = px * px;
      py_prod = py * py;
      ew = $signed({1'b0, mid_data.xmax}) - $signed({1'b0, mid_data.xmin});
      eh = $signed({1'b0, mid_data.ymax}) - $signed({1'b0, mid_data.ymin});
      dx_sq_in     = unsigned'(dx_prod);
      dy_sq_in     = unsigned'(dy_prod);
      px_sq_in     = unsigned'(px_prod);
      py_sq_in     = unsigned'(py_prod);
      area_prod_in = ew * eh;

      dc_sum    = {1'b0, dx_sq_ff} + {1'b0, dy_sq_ff};
      dp_sum    = {1'b0, px_sq_ff} + {1'b0, py_sq_ff};
      dc_wide   = dc_sum >> (FRAC_BITS + 1);
      dp_wide   = dp_sum >> (FRAC_BITS + 1);
      om_dc_in  = ONE_T - $signed({1'b0, dc_wide[TW-2:0]});
      om_dp_in  = prev_valid_ff ? (ONE_T - $signed({1'b0, dp_wide[TW-2:0]})) : '0;
      area_q_in = TW'(area_prod_ff >>> FRAC_BITS);

      t30_in = $signed({1'b0, W_30}) * om_dc_ff;
      t15_in = $signed({1'b0, W_15}) * om_dp_ff;
      t05_in = $signed({1'b0, W_05}) * area_q_ff;

      sh30       = t30_ff >>> FRAC_BITS;
      sh15       = t15_ff >>> FRAC_BITS;
      sh05       = t05_ff >>> FRAC_BITS;
      conf_half  = $signed({{(SCW - COORD_W + 1){1'b0}}, cur_conf_ff[COORD_W-1:1]});
      score_wide = conf_half + SCW'(sh30) + SCW'(sh15) + SCW'(sh05);
      if (score_wide > SAT_HI) begin
         score_sat = SC_W'(SAT_HI);
      end else if (score_wide < SAT_LO) begin
         score_sat = SC_W'(SAT_LO);
      end else begin
         score_sat = SC_W'(score_wide);
      end
      take = !best_valid_ff || (top_score_ff < 0) || (score_sat > top_score_ff);

      cx_sum = {1'b0, best_xmin_ff} + {1'b0, best_xmax_ff};
      cy_sum = {1'b0, best_ymin_ff} + {1'b0, best_ymax_ff};
   end

   always_comb begin
      out_data = '0;
      if (mid_data.kind == KIND_FRAME_END) begin
         out_data.result_kind = RESULT_SUMMARY;
         if (best_valid_ff) begin
            out_data.box_x        = best_xmin_ff;
            out_data.box_y        = best_ymin_ff;
            out_data.box_w        = span(best_xmin_ff, best_xmax_ff);
            out_data.box_h        = span(best_ymin_ff, best_ymax_ff);
            out_data.box_class    = best_class_ff;
            out_data.best_present = 1'b1;
         end
         if (found_reported_ff != found_in_frame_ff) begin
            out_data.status_event = found_in_frame_ff ? EVENT_DETECTED : EVENT_LOST;
         end else begin
            out_data.status_event = EVENT_NONE;
         end
      end else begin
         out_data.result_kind = RESULT_BOX;
         out_data.box_x       = mid_data.xmin;
         out_data.box_y       = mid_data.ymin;
         out_data.box_w       = span(mid_data.xmin, mid_data.xmax);
         out_data.box_h       = span(mid_data.ymin, mid_data.ymax);
         out_data.box_class   = mid_data.class_index;
      end
   end

   always_comb begin
      state_in          = state_ff;
      prev_valid_in     = prev_valid_ff;
      best_valid_in     = best_valid_ff;
      found_in_frame_in = found_in_frame_ff;
      found_reported_in = found_reported_ff;
      prev_cx_in        = prev_cx_ff;
      prev_cy_in        = prev_cy_ff;
      top_score_in      = top_score_ff;
      best_xmin_in      = best_xmin_ff;
      best_ymin_in      = best_ymin_ff;
      best_xmax_in      = best_xmax_ff;
      best_ymax_in      = best_ymax_ff;
      best_class_in     = best_class_ff;
      cur_xmin_in       = cur_xmin_ff;
      cur_ymin_in       = cur_ymin_ff;
      cur_xmax_in       = cur_xmax_ff;
      cur_ymax_in       = cur_ymax_ff;
      cur_conf_in       = cur_conf_ff;
      cur_class_in      = cur_class_ff;
      mid_pop           = 1'b0;
      out_push          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!mid_empty && !out_full) begin
               mid_pop  = 1'b1;
               out_push = 1'b1;
               if (mid_data.kind == KIND_FRAME_END) begin
                  prev_valid_in     = best_valid_ff;
                  prev_cx_in        = cx_sum[COORD_W:1];
                  prev_cy_in        = cy_sum[COORD_W:1];
                  found_reported_in = found_in_frame_ff;
                  found_in_frame_in = 1'b0;
                  best_valid_in     = 1'b0;
               end else begin
                  found_in_frame_in = 1'b1;
                  cur_xmin_in       = mid_data.xmin;
                  cur_ymin_in       = mid_data.ymin;
                  cur_xmax_in       = mid_data.xmax;
                  cur_ymax_in       = mid_data.ymax;
                  cur_conf_in       = mid_data.confidence;
                  cur_class_in      = mid_data.class_index;
                  state_in          = ST_SUM;
               end
            end
         end
         ST_SUM: begin
            state_in = ST_WGT;
         end
         ST_WGT: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (take) begin
               best_valid_in = 1'b1;
               top_score_in  = score_sat;
               best_xmin_in  = cur_xmin_ff;
               best_ymin_in  = cur_ymin_ff;
               best_xmax_in  = cur_xmax_ff;
               best_ymax_in  = cur_ymax_ff;
               best_class_in = cur_class_ff;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         prev_valid_ff     <= 1'b0;
         best_valid_ff     <= 1'b0;
         found_in_frame_ff <= 1'b0;
         found_reported_ff <= 1'b0;
      end else begin
         state_ff          <= state_in;
         prev_valid_ff     <= prev_valid_in;
         best_valid_ff     <= best_valid_in;
         found_in_frame_ff <= found_in_frame_in;
         found_reported_ff <= found_reported_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_cx_ff    <= prev_cx_in;
      prev_cy_ff    <= prev_cy_in;
      top_score_ff  <= top_score_in;
      best_xmin_ff  <= best_xmin_in;
      best_ymin_ff  <= best_ymin_in;
      best_xmax_ff  <= best_xmax_in;
      best_ymax_ff  <= best_ymax_in;
      best_class_ff <= best_class_in;
      cur_xmin_ff   <= cur_xmin_in;
      cur_ymin_ff   <= cur_ymin_in;
      cur_xmax_ff   <= cur_xmax_in;
      cur_ymax_ff   <= cur_ymax_in;
      cur_conf_ff   <= cur_conf_in;
      cur_class_ff  <= cur_class_in;
      dx_sq_ff      <= dx_sq_in;
      dy_sq_ff      <= dy_sq_in;
      px_sq_ff      <= px_sq_in;
      py_sq_ff      <= py_sq_in;
      area_prod_ff  <= area_prod_in;
      om_dc_ff      <= om_dc_in;
      om_dp_ff      <= om_dp_in;
      area_q_ff     <= area_q_in;
      t30_ff        <= t30_in;
      t15_ff        <= t15_in;
      t05_ff        <= t05_in;
   end

endmodule

FILE: design/detection_target_selector.sv
// ----------------------------------------------------------------------------
// Detection target selector
// A result beat passes the mid queue and then the result queue, both
// registered, before it is on the result ports. A scored box holds the back
// end through its square, sum, weight and compare steps; a frame end is
// handled in the idle state; dropped boxes never reach the back end.
// Synchronous reset restores register defaults, empties both queues and
// clears the best-box and detection tracking.
// ----------------------------------------------------------------------------
module detection_target_selector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [dts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dts_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            req_push,
   output logic                            req_full,
   input  dts_pkg::req_type                req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output dts_pkg::rsp_type                rsp_data
);

   import dts_pkg::*;

   localparam int QUEUE_DEPTH = 2;

   logic    mid_push, mid_full, mid_pop, mid_empty;
   mid_type mid_in_data, mid_out_data;
   logic    out_push, out_full;
   rsp_type out_data;

   dts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .mid_full  (mid_full),
      .mid_push  (mid_push),
      .mid_data  (mid_in_data)
   );

   dts_fifo #(
      .WIDTH ($bits(mid_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (mid_in_data),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (mid_out_data),
      .empty     (mid_empty)
   );

   dts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mid_empty (mid_empty),
      .mid_pop   (mid_pop),
      .mid_data  (mid_out_data),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   dts_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

FILE: test/detection_target_selector_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection target selector checker
// Watches the register, box and result channels of the selector. Every
// accepted box or frame end is run through a bit-accurate score and best-box
// predictor, and every result beat is compared field by field with the oldest
// predicted result. Mismatches and the number of results still owed go to the
// top.
// ----------------------------------------------------------------------------
module detection_target_selector_check (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [dts_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [dts_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic                            req_push,
   input  logic                            req_full,
   input  dts_pkg::req_type                req_data,
   input  logic                            rsp_empty,
   input  logic                            rsp_pop,
   input  dts_pkg::rsp_type                rsp_data,
   output int                              mismatches,
   output int                              outstanding
);
   import dts_pkg::*;

   localparam longint UNIT          = longint'(1) << FRAC_BITS;
   localparam longint CENTER_WEIGHT = (3 * UNIT + 5) / 10;
   localparam longint TRACK_WEIGHT  = (3 * UNIT + 10) / 20;
   localparam longint AREA_WEIGHT   = (UNIT + 10) / 20;
   localparam int     SCORE_W       = 19;
   localparam longint SCORE_CEIL    = (longint'(1) << (SCORE_W - 1)) - 1;
   localparam longint SCORE_FLOOR   = -(longint'(1) << (SCORE_W - 1));

   logic [COORD_W-1:0] min_confidence;
   logic [MASK_W-1:0]  class_filter;
   logic               have_last;
   logic [COORD_W-1:0] last_cx;
   logic [COORD_W-1:0] last_cy;
   logic               have_best;
   longint             lead_score;
   req_type            best_item;
   logic               seen_in_frame;
   logic               seen_reported;
   rsp_type            predicted_results[$];
   rsp_type            oldest;

   task automatic report_mismatch(input string line);
      if (mismatches < 30)
         $display("%0t mismatch: %s", $time, line);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [COORD_W-1:0] got,
                                input logic [COORD_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
   endtask

   function automatic longint sq_dist(input longint dx, input longint dy);
      return (dx * dx + dy * dy) >> (FRAC_BITS + 1);
   endfunction

   function automatic longint weigh(input longint weight, input longint value);
      return (weight * value) >>> FRAC_BITS;
   endfunction

   function automatic rsp_type report_beat(input logic kind, input req_type box);
      rsp_type beat;
      beat = '0;
      beat.result_kind = kind;
      beat.box_x = box.xmin;
      beat.box_y = box.ymin;
      beat.box_w = (box.xmax > box.xmin) ? box.xmax - box.xmin : '0;
      beat.box_h = (box.ymax > box.ymin) ? box.ymax - box.ymin : '0;
      beat.box_class = box.class_index;
      return beat;
   endfunction

   task automatic predict_selection(input req_type item);
      longint  sx;
      longint  sy;
      longint  near_center;
      longint  near_last;
      longint  area;
      longint  score;
      rsp_type summary;
      if (item.kind == KIND_FRAME_END) begin
         summary = report_beat(RESULT_SUMMARY, have_best ? best_item : req_type'('0));
         summary.best_present = have_best;
         summary.status_event = EVENT_NONE;
         if (have_best) begin
            last_cx = COORD_W'((longint'(best_item.xmin) + longint'(best_item.xmax)) >> 1);
            last_cy = COORD_W'((longint'(best_item.ymin) + longint'(best_item.ymax)) >> 1);
         end
         have_last = have_best;
         if (seen_reported != seen_in_frame) begin
            summary.status_event = seen_in_frame ? EVENT_DETECTED : EVENT_LOST;
            seen_reported = seen_in_frame;
         end
         predicted_results = {predicted_results, summary};
         have_best = 1'b0;
         lead_score = 0;
         seen_in_frame = 1'b0;
         return;
      end
      if (int'(item.class_index) >= NUM_CLASSES)
         return;
      if (class_filter != '0 && !class_filter[item.class_index])
         return;
      if (item.confidence < min_confidence)
         return;
      seen_in_frame = 1'b1;
      sx = longint'(item.xmin) + longint'(item.xmax);
      sy = longint'(item.ymin) + longint'(item.ymax);
      near_center = sq_dist(sx - UNIT, sy - UNIT);
      near_last = have_last ? sq_dist(sx - 2 * longint'(last_cx), sy - 2 * longint'(last_cy))
                            : UNIT;
      area = ((longint'(item.xmax) - longint'(item.xmin)) *
              (longint'(item.ymax) - longint'(item.ymin))) >>> FRAC_BITS;
      score = longint'(item.confidence >> 1) + weigh(CENTER_WEIGHT, UNIT - near_center)
            + weigh(TRACK_WEIGHT, UNIT - near_last) + weigh(AREA_WEIGHT, area);
      if (score > SCORE_CEIL)
         score = SCORE_CEIL;
      if (score < SCORE_FLOOR)
         score = SCORE_FLOOR;
      if (!have_best || lead_score < 0 || score > lead_score) begin
         have_best = 1'b1;
         lead_score = score;
         best_item = item;
      end
      predicted_results = {predicted_results, report_beat(RESULT_BOX, item)};
   endtask

   always @(posedge clock) begin
      if (reset) begin
         min_confidence = CONF_THRESHOLD_RESET;
         class_filter = '0;
         have_last = 1'b0;
         last_cx = '0;
         last_cy = '0;
         have_best = 1'b0;
         lead_score = 0;
         best_item = '0;
         seen_in_frame = 1'b0;
         seen_reported = 1'b0;
         predicted_results.delete();
         mismatches = 0;
      end else begin
         if (!rsp_empty && rsp_pop) begin
            if (predicted_results.size() == 0) begin
               report_mismatch($sformatf("result beat 0x%h with nothing predicted", rsp_data));
            end else begin
               oldest = predicted_results.pop_front();
               compare_field("result_kind", rsp_data.result_kind, oldest.result_kind);
               compare_field("box_x", rsp_data.box_x, oldest.box_x);
               compare_field("box_y", rsp_data.box_y, oldest.box_y);
               compare_field("box_w", rsp_data.box_w, oldest.box_w);
               compare_field("box_h", rsp_data.box_h, oldest.box_h);
               compare_field("box_class", rsp_data.box_class, oldest.box_class);
               compare_field("best_present", rsp_data.best_present, oldest.best_present);
               compare_field("status_event", rsp_data.status_event, oldest.status_event);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CONF_THRESHOLD: begin
                  min_confidence = csr_data[COORD_W-1:0];
               end
               CSR_CLASS_MASK: begin
                  class_filter = csr_data[MASK_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_push && !req_full)
            predict_selection(req_data);
      end
      outstanding = predicted_results.size();
   end

endmodule

FILE: test/detection_target_selector_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detection target selector testbench
// Drives directed frames that hit the threshold edge, inverted and oversized
// boxes, score ties, negative held scores, class filtering and the detected
// and lost events, then random frames under six register settings. Both
// channels idle at random, except for one phase without gaps. The checker
// beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module detection_target_selector_test;
   import dts_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_TICKS = 16;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  req_push;
   logic                  req_full;
   req_type               req_data;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   rsp_type               rsp_data;
   logic                  calm = 1'b0;
   int                    check_failures;
   int                    results_owed;
   int                    quiet_cycles = 0;

   detection_target_selector dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   detection_target_selector_check selection_check (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .mismatches  (check_failures),
      .outstanding (results_owed)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_pop <= calm || ($urandom_range(99) >= 12);
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (!rsp_empty && rsp_pop) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic req_type box_beat(input int cls, input int x0, input int y0,
                                        input int x1, input int y1, input int conf);
      req_type item;
      item.kind = KIND_BOX;
      item.class_index = CLASS_W'(cls);
      item.xmin = COORD_W'(x0);
      item.ymin = COORD_W'(y0);
      item.xmax = COORD_W'(x1);
      item.ymax = COORD_W'(y1);
      item.confidence = COORD_W'(conf);
      return item;
   endfunction

   function automatic req_type frame_end_beat();
      req_type item;
      item = '0;
      item.kind = KIND_FRAME_END;
      return item;
   endfunction

   function automatic req_type random_item();
      logic [95:0] bits;
      req_type     item;
      int          pick;
      int          x0;
      int          y0;
      bits = {$urandom, $urandom, $urandom};
      pick = $urandom_range(99);
      x0 = $urandom_range(0, 65536);
      y0 = $urandom_range(0, 65536);
      if (pick < 12) begin
         item = bits[$bits(req_type)-1:0];
         item.kind = KIND_FRAME_END;
      end else if (pick < 24) begin
         item = bits[$bits(req_type)-1:0];
         item.kind = KIND_BOX;
      end else begin
         item = box_beat($urandom_range(0, 63), x0, y0, $urandom_range(x0, 65536),
                         $urandom_range(y0, 65536), $urandom_range(0, 65536));
      end
      return item;
   endfunction

   task automatic send_beat(input req_type beat);
      logic was_full;
      while (!calm && $urandom_range(99) < 12) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= beat;
      do begin
         @(negedge clock);
         was_full = req_full;
         @(posedge clock);
      end while (was_full);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      logic was_ready;
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do begin
         @(negedge clock);
         was_ready = csr_ready;
         @(posedge clock);
      end while (!was_ready);
   endtask

   // An unknown index is written too; the block must ignore it.
   task automatic configure(input logic [COORD_W-1:0] threshold,
                            input logic [MASK_W-1:0] mask);
      write_reg(CSR_CONF_THRESHOLD, CSR_DATA_W'(threshold));
      write_reg(CSR_CLASS_MASK, mask);
      write_reg(CSR_IDX_W'($urandom_range(2, 15)), {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   // Dropped boxes leave no result, so the pause lets any still in flight drain.
   task automatic settle();
      req_push <= 1'b0;
      do @(negedge clock); while (results_owed != 0);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   initial begin
      reset <= 1'b1;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      req_push <= 1'b0;
      req_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_beat(frame_end_beat());
      send_beat(box_beat(0, 0, 0, 0, 0, 32768));
      send_beat(box_beat(5, 1000, 1000, 2000, 2000, 32767));
      send_beat(box_beat(63, 0, 0, 65536, 65536, 65536));
      send_beat(box_beat(7, 50000, 10000, 10000, 60000, 131071));
      send_beat(frame_end_beat());
      send_beat(box_beat(1, 20000, 20000, 40000, 40000, 60000));
      send_beat(box_beat(2, 20000, 20000, 40000, 40000, 60000));
      send_beat('1);
      send_beat(frame_end_beat());

      settle();
      configure('0, 64'h8000_0000_0000_0318);
      send_beat(box_beat(8, 0, 0, 0, 0, 0));
      send_beat(frame_end_beat());
      // Far outside the frame with zero confidence: the score saturates low,
      // and an equal box after it still replaces the negative best.
      send_beat(box_beat(3, 131071, 131071, 131071, 131071, 0));
      send_beat(box_beat(4, 131071, 131071, 131071, 131071, 0));
      send_beat(box_beat(10, 100, 100, 30000, 30000, 65536));
      send_beat(box_beat(9, 30000, 30000, 36000, 36000, 1));
      send_beat(frame_end_beat());

      settle();
      configure(COORD_W'(65536), '1);
      send_beat(box_beat(33, 10000, 10000, 50000, 50000, 65535));
      send_beat(box_beat(33, 10000, 10000, 50000, 50000, 65536));
      send_beat(frame_end_beat());
      send_beat(frame_end_beat());
      send_beat(frame_end_beat());

      for (int phase = 0; phase < 6; phase++) begin
         settle();
         case (phase)
            0: begin
               configure('0, '1);
            end
            1: begin
               configure(COORD_W'(65536), '0);
            end
            2: begin
               configure(COORD_W'($urandom_range(0, 40000)), {$urandom, $urandom});
            end
            3: begin
               configure(COORD_W'($urandom_range(0, 65536)), 64'd1 << $urandom_range(0, 63));
            end
            4: begin
               configure(CONF_THRESHOLD_RESET, {$urandom, $urandom} | {$urandom, $urandom});
            end
            default: begin
               configure(COORD_W'($urandom_range(0, 65536)), '0);
            end
         endcase
         calm <= (phase == 2);
         repeat (125) send_beat(random_item());
      end

      settle();
      if (check_failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
